[src/assert_macros.svh]
// Assertion macros included by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/pts_pkg.sv]
// Types and constants of the periodic topic scheduler.
`default_nettype none

package pts_pkg;

   localparam int TOPICS = 16;
   localparam int TOPIC_W = (TOPICS > 1) ? $clog2(TOPICS) : 1;
   localparam logic [31:0] DEFAULT_PERIOD = 32'd100;
   localparam logic [31:0] PERIOD_NONE = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      ACT_SUBSCRIBE   = 2'd0,
      ACT_UNSUBSCRIBE = 2'd1,
      ACT_CONTEXT     = 2'd2,
      ACT_TICK        = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_CONTEXT = 2'd1,
      KIND_DUE     = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CTX,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] period;
      logic [31:0] last_fire;
   } entry_type;

endpackage

`default_nettype wire

[src/periodic_topic_scheduler.sv]
// Periodic topic scheduler: topic table in one synchronous RAM, scanned on tick.
`default_nettype none

// A command is transferred at a rising edge with start high and busy low.
// For subscribe and unsubscribe the acknowledge appears on the rsp_ ports
// in the next cycle and a new command may be transferred in that same
// cycle. Get context reads the topic RAM through its read register, so busy
// is high in the context state and the reply passes that register and then
// the result register; a topic number out of range is answered in the next
// cycle with ok low and period -1. A tick walks the RAM one entry per cycle
// and keeps busy high through scan and flush, which sets the tick rate.
// Due topics come out in ascending order, one per strobe, and the final one
// of a tick carries rsp_last. A tick with nothing due gives no strobe.
// Each result is presented for exactly one cycle and cannot be held off:
// the receiver must take every strobe. After reset the table reads as
// period 100, last-fire 0, disabled, without any clearing pass.
module periodic_topic_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_topic,
   input  wire logic [31:0] req_period,
   input  wire logic [31:0] req_now,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_kind,
   output logic             rsp_ok,
   output logic [7:0]       rsp_topic_id,
   output logic [31:0]      rsp_period_out,
   output logic             rsp_enabled,
   output logic             rsp_last
);

`include "assert_macros.svh"

   localparam int TW = pts_pkg::TOPIC_W;

   // topic RAM: period and last-fire time per entry
   pts_pkg::entry_type mem [0:pts_pkg::TOPICS-1];
   pts_pkg::entry_type rd_data_ff;
   logic               wr_en;
   logic [TW-1:0]      wr_addr;
   pts_pkg::entry_type wr_data;
   logic [TW-1:0]      rd_addr;

   // control state
   pts_pkg::state_type state_ff, state_in;
   logic [TW-1:0]      idx_ff, idx_in;
   logic [31:0]        now_ff, now_in;
   logic [pts_pkg::TOPICS-1:0] enable_ff, enable_in;
   logic [pts_pkg::TOPICS-1:0] written_ff, written_in;

   // one due topic held back until we know whether it is the final one
   logic               pend_valid_ff, pend_valid_in;
   logic [TW-1:0]      pend_topic_ff, pend_topic_in;
   logic [31:0]        pend_period_ff, pend_period_in;

   // result register
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]         rsp_kind_ff, rsp_kind_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [7:0]         rsp_topic_id_ff, rsp_topic_id_in;
   logic [31:0]        rsp_period_ff, rsp_period_in;
   logic               rsp_enabled_ff, rsp_enabled_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               in_range;
   logic [TW-1:0]      req_idx;
   logic [31:0]        cur_period;
   logic [31:0]        cur_last_fire;
   logic [31:0]        elapsed;
   logic               due;

   assign busy     = (state_ff != pts_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign in_range = (req_topic < 8'(pts_pkg::TOPICS));
   assign req_idx  = req_topic[TW-1:0];

   // entries never written read as their reset values
   assign cur_period    = written_ff[idx_ff] ? rd_data_ff.period : pts_pkg::DEFAULT_PERIOD;
   assign cur_last_fire = written_ff[idx_ff] ? rd_data_ff.last_fire : 32'd0;
   assign elapsed       = now_ff - cur_last_fire;
   assign due           = enable_ff[idx_ff] && ($signed(elapsed) > $signed(cur_period));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pts_pkg::ST_IDLE;
         enable_ff     <= '0;
         written_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         written_ff    <= written_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      now_ff          <= now_in;
      pend_topic_ff   <= pend_topic_in;
      pend_period_ff  <= pend_period_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_ok_ff       <= rsp_ok_in;
      rsp_topic_id_ff <= rsp_topic_id_in;
      rsp_period_ff   <= rsp_period_in;
      rsp_enabled_ff  <= rsp_enabled_in;
      rsp_last_ff     <= rsp_last_in;
   end

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      now_in          = now_ff;
      enable_in       = enable_ff;
      written_in      = written_ff;
      pend_valid_in   = pend_valid_ff;
      pend_topic_in   = pend_topic_ff;
      pend_period_in  = pend_period_ff;
      rsp_strobe_in   = 1'b0;
      rsp_kind_in     = rsp_kind_ff;
      rsp_ok_in       = rsp_ok_ff;
      rsp_topic_id_in = rsp_topic_id_ff;
      rsp_period_in   = rsp_period_ff;
      rsp_enabled_in  = rsp_enabled_ff;
      rsp_last_in     = rsp_last_ff;
      wr_en           = 1'b0;
      wr_addr         = idx_ff;
      wr_data         = '{period: cur_period, last_fire: now_ff};
      rd_addr         = idx_ff + 1'b1;

      case (state_ff)
         pts_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  pts_pkg::ACT_SUBSCRIBE: begin
                     if (in_range) begin
                        wr_en               = 1'b1;
                        wr_addr             = req_idx;
                        wr_data             = '{period: req_period, last_fire: 32'd0};
                        written_in[req_idx] = 1'b1;
                        enable_in[req_idx]  = 1'b1;
                     end
                     rsp_strobe_in   = 1'b1;
                     rsp_kind_in     = pts_pkg::KIND_ACK;
                     rsp_ok_in       = in_range;
                     rsp_topic_id_in = 8'd0;
                     rsp_period_in   = 32'd0;
                     rsp_enabled_in  = 1'b0;
                     rsp_last_in     = 1'b1;
                  end
                  pts_pkg::ACT_UNSUBSCRIBE: begin
                     if (in_range) begin
                        enable_in[req_idx] = 1'b0;
                     end
                     rsp_strobe_in   = 1'b1;
                     rsp_kind_in     = pts_pkg::KIND_ACK;
                     rsp_ok_in       = in_range;
                     rsp_topic_id_in = 8'd0;
                     rsp_period_in   = 32'd0;
                     rsp_enabled_in  = 1'b0;
                     rsp_last_in     = 1'b1;
                  end
                  pts_pkg::ACT_CONTEXT: begin
                     if (in_range) begin
                        rd_addr  = req_idx;
                        idx_in   = req_idx;
                        state_in = pts_pkg::ST_CTX;
                     end else begin
                        rsp_strobe_in   = 1'b1;
                        rsp_kind_in     = pts_pkg::KIND_CONTEXT;
                        rsp_ok_in       = 1'b0;
                        rsp_topic_id_in = 8'd0;
                        rsp_period_in   = pts_pkg::PERIOD_NONE;
                        rsp_enabled_in  = 1'b0;
                        rsp_last_in     = 1'b1;
                     end
                  end
                  pts_pkg::ACT_TICK: begin
                     rd_addr       = '0;
                     idx_in        = '0;
                     now_in        = req_now;
                     pend_valid_in = 1'b0;
                     state_in      = pts_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = pts_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         pts_pkg::ST_CTX: begin
            rsp_strobe_in   = 1'b1;
            rsp_kind_in     = pts_pkg::KIND_CONTEXT;
            rsp_ok_in       = 1'b1;
            rsp_topic_id_in = 8'd0;
            rsp_period_in   = cur_period;
            rsp_enabled_in  = enable_ff[idx_ff];
            rsp_last_in     = 1'b1;
            state_in        = pts_pkg::ST_IDLE;
         end

         pts_pkg::ST_SCAN: begin
            // read data for idx_ff is here; the read of idx_ff + 1 is issued
            if (due) begin
               wr_en              = 1'b1;
               written_in[idx_ff] = 1'b1;
               if (pend_valid_ff) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_kind_in     = pts_pkg::KIND_DUE;
                  rsp_ok_in       = 1'b1;
                  rsp_topic_id_in = 8'(pend_topic_ff);
                  rsp_period_in   = pend_period_ff;
                  rsp_enabled_in  = 1'b1;
                  rsp_last_in     = 1'b0;
               end
               pend_valid_in  = 1'b1;
               pend_topic_in  = idx_ff;
               pend_period_in = cur_period;
            end
            if (idx_ff == TW'(pts_pkg::TOPICS - 1)) begin
               state_in = pts_pkg::ST_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         pts_pkg::ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_strobe_in   = 1'b1;
               rsp_kind_in     = pts_pkg::KIND_DUE;
               rsp_ok_in       = 1'b1;
               rsp_topic_id_in = 8'(pend_topic_ff);
               rsp_period_in   = pend_period_ff;
               rsp_enabled_in  = 1'b1;
               rsp_last_in     = 1'b1;
            end
            pend_valid_in = 1'b0;
            state_in      = pts_pkg::ST_IDLE;
         end

         default: begin
            state_in = pts_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_topic_id   = rsp_topic_id_ff;
   assign rsp_period_out = rsp_period_ff;
   assign rsp_enabled    = rsp_enabled_ff;
   assign rsp_last       = rsp_last_ff;

   // acknowledges and context replies are always the only result of their command
   `ASSERT_IMPL(a_single_reply_last, clock, reset,
      rsp_strobe && (rsp_kind != pts_pkg::KIND_DUE), rsp_last)
   // a transferred tick always starts a scan
   `ASSERT_NEXT(a_tick_scans, clock, reset,
      accept && (req_action == pts_pkg::ACT_TICK), state_ff == pts_pkg::ST_SCAN)
   // a held-back due topic never survives past the flush cycle
   `ASSERT_NEXT(a_flush_drains, clock, reset,
      state_ff == pts_pkg::ST_FLUSH, !pend_valid_ff && !busy)

endmodule

`default_nettype wire
